@@ hw/rtl/ssba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Swap slot bitmap allocator package
// Shared sizes, status codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package ssba_pkg;

    localparam int MAX_SLOTS        = 1024;
    localparam int SECTORS_PER_PAGE = 8;

    localparam int SLOT_W   = 10;
    localparam int SECTOR_W = 13;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam int ROW_W     = 32;
    localparam int BIT_W     = $clog2(ROW_W);
    localparam int ROWS      = MAX_SLOTS / ROW_W;
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W     = (SECTORS_PER_PAGE > 1) ? $clog2(SECTORS_PER_PAGE) : 1;
    localparam int PROD_W    = SLOT_W + 7;

    localparam logic [COUNT_W-1:0] MAX_COUNT   = COUNT_W'(MAX_SLOTS);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
    localparam logic [CNT_W-1:0]   CNT_LAST    = CNT_W'(SECTORS_PER_PAGE - 1);

    localparam logic [STATUS_W-1:0] ST_OK         = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_FULL       = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = STATUS_W'(2);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic ready;
        logic load;
        logic lookup;
        logic decide;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic last_item;
    } t_stat;

endpackage
`default_nettype wire

@@ hw/rtl/ssba_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate or free request per transaction.
// ----------------------------------------------------------------------------
interface ssba_req_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [ssba_pkg::SLOT_W-1:0]    slot_number;

    modport source (output valid, output action, output slot_number, input ready);
    modport sink   (input valid, input action, input slot_number, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ssba_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one sector address or status per transaction.
// ----------------------------------------------------------------------------
interface ssba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ssba_pkg::SLOT_W-1:0]    slot;
    logic [ssba_pkg::SECTOR_W-1:0]  sector_address;
    logic [ssba_pkg::STATUS_W-1:0]  status;
    logic                           last;

    modport source (output valid, output slot, output sector_address, output status,
                    output last, input ready);
    modport sink   (input valid, input slot, input sector_address, input status,
                    input last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/swap_slot_bitmap_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Swap slot bitmap allocator
// First-fit allocation and release of swap slots with sector run output.
// ----------------------------------------------------------------------------
// The used-slot bitmap lives in a 32-word by 32-bit RAM; per-row valid and full
// flags in flip-flops clear at reset, so the block is ready right after reset
// with no clearing pass. A request passes an accept state, a RAM read state
// and a decision state, then emits its results one per cycle through an
// output register while the response channel is ready: a sector run of 8
// addresses, or a single status. A new request is taken only after the last
// result is emitted. The single RAM read per request sets the lookup time;
// the first-fit search is a priority encode over the row full flags
// followed by one over the fetched word.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [ssba_pkg::COUNT_W-1:0]   i_cfg_wr_data,
    ssba_req_if.sink                            i_req,
    ssba_rsp_if.source                          o_rsp
);
    import ssba_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ssba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ssba_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_action         (i_req.action),
        .i_slot_number    (i_req.slot_number),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_valid          (o_rsp.valid),
        .i_ready          (o_rsp.ready),
        .o_slot           (o_rsp.slot),
        .o_sector_address (o_rsp.sector_address),
        .o_status         (o_rsp.status),
        .o_last           (o_rsp.last)
    );

    assign i_req.ready = cmd.ready;

    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.lookup)
        else $error("accepted request not followed by lookup");

    a_lookup_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.lookup |=> cmd.decide)
        else $error("lookup not followed by decision");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result emitted over a pending result");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> o_rsp.last)
        else $error("status result not flagged last");
endmodule
`default_nettype wire

@@ hw/rtl/ssba_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/ssba_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences accept, bitmap lookup, decision and result emission.
// ----------------------------------------------------------------------------
module ssba_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    input  wire ssba_pkg::t_stat i_stat,
    output ssba_pkg::t_cmd      o_cmd
);
    import ssba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_DECIDE = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd.ready  = (r_state == S_IDLE);
        o_cmd.load   = (r_state == S_IDLE) && i_req_valid;
        o_cmd.lookup = (r_state == S_LOOKUP);
        o_cmd.decide = (r_state == S_DECIDE);
        o_cmd.emit   = (r_state == S_EMIT) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_LOOKUP;
            end
            S_LOOKUP: n_state = S_DECIDE;
            S_DECIDE: n_state = S_EMIT;
            S_EMIT: begin
                if (i_stat.out_free && i_stat.last_item) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/ssba_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator datapath
// Bitmap RAM with row flags, first-fit search, sector run and output register.
// ----------------------------------------------------------------------------
module ssba_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [ssba_pkg::COUNT_W-1:0]       i_cfg_wr_data,
    input  wire logic                               i_action,
    input  wire logic [ssba_pkg::SLOT_W-1:0]        i_slot_number,
    input  wire ssba_pkg::t_cmd                     i_cmd,
    output ssba_pkg::t_stat                         o_stat,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic      [ssba_pkg::SLOT_W-1:0]        o_slot,
    output logic      [ssba_pkg::SECTOR_W-1:0]      o_sector_address,
    output logic      [ssba_pkg::STATUS_W-1:0]      o_status,
    output logic                                    o_last
);
    import ssba_pkg::*;

    logic [COUNT_W-1:0]   r_slot_count;
    logic                 r_action;
    logic [SLOT_W-1:0]    r_req;
    logic [ROW_IDX_W-1:0] r_row, n_row;
    logic                 r_any, n_any;
    logic [ROWS-1:0]      r_row_full;
    logic [ROWS-1:0]      r_row_valid;

    logic [ROW_W-1:0]     ram_rdata;
    logic [ROW_W-1:0]     word, mask, new_word;
    logic [BIT_W-1:0]     first_zero, req_bit, sel_bit;
    logic [SLOT_W-1:0]    alloc_slot, res_slot;
    logic [COUNT_W-1:0]   eff_count;
    logic                 alloc_ok, free_ok, ok;
    logic [STATUS_W-1:0]  res_status;
    logic [PROD_W-1:0]    prod;

    logic [SLOT_W-1:0]    r_slot;
    logic [STATUS_W-1:0]  r_status;
    logic [SECTOR_W-1:0]  r_base;
    logic [CNT_W-1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_slot_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_req    <= i_slot_number;
        end
    end

    always_comb begin
        n_any = 1'b0;
        n_row = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (!r_row_full[i]) begin
                n_any = 1'b1;
                n_row = ROW_IDX_W'(i);
            end
        end
        if (r_action == ACT_FREE) begin
            n_any = 1'b1;
            n_row = r_req[BIT_W +: ROW_IDX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_row <= n_row;
            r_any <= n_any;
        end
    end

    ssba_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (i_cmd.decide && ok),
        .i_waddr (r_row),
        .i_wdata (new_word),
        .i_re    (i_cmd.lookup),
        .i_raddr (n_row),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        word       = r_row_valid[r_row] ? ram_rdata : '0;
        first_zero = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (!word[i]) first_zero = BIT_W'(i);
        end
        eff_count  = (r_slot_count > MAX_COUNT) ? MAX_COUNT : r_slot_count;
        alloc_slot = SLOT_W'({r_row, first_zero});
        alloc_ok   = r_any && (COUNT_W'(alloc_slot) < eff_count);
        req_bit    = r_req[BIT_W-1:0];
        free_ok    = (COUNT_W'(r_req) < eff_count) && word[req_bit];
        sel_bit    = (r_action == ACT_FREE) ? req_bit : first_zero;
        mask       = ROW_W'(1) << sel_bit;
        new_word   = (r_action == ACT_FREE) ? (word & ~mask) : (word | mask);
        ok         = (r_action == ACT_FREE) ? free_ok : alloc_ok;
        if (r_action == ACT_FREE) begin
            res_slot = r_req;
        end else begin
            res_slot = alloc_ok ? alloc_slot : '0;
        end
        if (ok) begin
            res_status = ST_OK;
        end else begin
            res_status = (r_action == ACT_FREE) ? ST_NOT_IN_USE : ST_FULL;
        end
        prod = PROD_W'(res_slot) * PROD_W'(SECTORS_PER_PAGE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_full  <= '0;
            r_row_valid <= '0;
        end else if (i_cmd.decide && ok) begin
            r_row_valid[r_row] <= 1'b1;
            r_row_full[r_row]  <= &new_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_slot   <= res_slot;
            r_status <= res_status;
            r_base   <= prod[SECTOR_W-1:0];
            r_cnt    <= '0;
        end else if (i_cmd.emit) begin
            r_cnt    <= r_cnt + CNT_W'(1);
        end
    end

    assign o_stat.out_free  = !o_valid || i_ready;
    assign o_stat.last_item = (r_status != ST_OK) || (r_cnt == CNT_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_slot           <= r_slot;
            o_sector_address <= (r_status == ST_OK) ? (r_base + SECTOR_W'(r_cnt)) : '0;
            o_status         <= r_status;
            o_last           <= o_stat.last_item;
        end
    end
endmodule
`default_nettype wire
